// ===== design/address_region_table_defines.svh =====
// ----------------------------------------------------------------------------
// Address region table assertion macros
// Clocked assertion helpers for the region table RTL.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_REGION_TABLE_DEFINES_SVH
`define ADDRESS_REGION_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define ART_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("address_region_table assertion failed");
`define ART_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("address_region_table implication failed");
`else
`define ART_ASSERT(lbl, prop)
`define ART_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== design/art_pkg.sv =====
// ----------------------------------------------------------------------------
// Address region table package
// Command and status codes, register indexes, reset defaults and row and cell control types.
// ----------------------------------------------------------------------------
package art_pkg;

    typedef enum logic [2:0] {
        CMD_MAP,
        CMD_MAP_NOREPLACE,
        CMD_UNMAP,
        CMD_PROTECT,
        CMD_CHECK,
        CMD_FIND_FREE,
        CMD_LOOKUP,
        CMD_RESERVED
    } art_cmd_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_INVALID,
        ST_EXISTS,
        ST_NOMEM,
        ST_FAULT,
        ST_OVERFLOW
    } art_status_t;

    typedef enum logic [1:0] {
        CFG_USER_LOW,
        CFG_USER_TOP,
        CFG_MMAP_BASE,
        CFG_STACK_FLOOR
    } art_cfg_idx_t;

    localparam logic [31:0] RST_USER_LOW    = 32'h0000_1000;
    localparam logic [31:0] RST_USER_TOP    = 32'hC000_0000;
    localparam logic [31:0] RST_MMAP_BASE   = 32'h1000_0000;
    localparam logic [31:0] RST_STACK_FLOOR = 32'h0000_0000;
    localparam logic [31:0] STACK_GUARD     = 32'h0001_0000;

    // table-wide update issued by the sequencer
    typedef struct packed {
        logic insert;
        logic remove;
        logic set_perm;
    } art_row_op_t;

    // per-cell load control
    typedef struct packed {
        logic load_new;
        logic take_prev;
        logic take_next;
        logic set_perm;
    } art_cell_ctl_t;

endpackage

// ===== design/art_if.sv =====
// ----------------------------------------------------------------------------
// Address region table channels
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface art_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [31:0] base_address;
    logic [31:0] length;
    logic [2:0]  perms;

    modport source (output valid, command, base_address, length, perms, input ready);
    modport sink (input valid, command, base_address, length, perms, output ready);
endinterface

interface art_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] result_address;
    logic [31:0] result_length;
    logic [2:0]  result_perms;
    logic        found;

    modport source (output valid, status, result_address, result_length, result_perms,
                    found, input ready);
    modport sink (input valid, status, result_address, result_length, result_perms,
                  found, output ready);
endinterface

// ===== design/art_cell.sv =====
// ----------------------------------------------------------------------------
// Address region table cell
// Holds one region; loads new data, shifts from a neighbor or updates its permissions.
// ----------------------------------------------------------------------------
module art_cell #(
    parameter int PW = 20
) (
    input  logic                   clk,
    input  art_pkg::art_cell_ctl_t ctl,
    input  logic [PW-1:0]          new_start,
    input  logic [PW-1:0]          new_count,
    input  logic [2:0]             new_perm,
    input  logic [PW-1:0]          prev_start,
    input  logic [PW-1:0]          prev_count,
    input  logic [2:0]             prev_perm,
    input  logic [PW-1:0]          next_start,
    input  logic [PW-1:0]          next_count,
    input  logic [2:0]             next_perm,
    output logic [PW-1:0]          start,
    output logic [PW-1:0]          count,
    output logic [2:0]             perm
);
    import art_pkg::*;

    logic [PW-1:0] start_reg;
    logic [PW-1:0] count_reg;
    logic [2:0]    perm_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load_new)
        begin
            start_reg <= new_start;
            count_reg <= new_count;
            perm_reg  <= new_perm;
        end
        else if (ctl.take_prev)
        begin
            start_reg <= prev_start;
            count_reg <= prev_count;
            perm_reg  <= prev_perm;
        end
        else if (ctl.take_next)
        begin
            start_reg <= next_start;
            count_reg <= next_count;
            perm_reg  <= next_perm;
        end
        else if (ctl.set_perm)
        begin
            perm_reg <= new_perm;
        end
    end

    assign start = start_reg;
    assign count = count_reg;
    assign perm  = perm_reg;

endmodule

// ===== design/art_cell_row.sv =====
// ----------------------------------------------------------------------------
// Address region table cell row
// Sorted row of region cells with insert, remove and permission update.
// ----------------------------------------------------------------------------
module art_cell_row #(
    parameter int N    = 16,
    parameter int PW   = 20,
    parameter int CNTW = 5
) (
    input  logic                 clk,
    input  art_pkg::art_row_op_t op,
    input  logic [CNTW-1:0]      pos,
    input  logic [PW-1:0]        new_start,
    input  logic [PW-1:0]        new_count,
    input  logic [2:0]           new_perm,
    output logic [PW-1:0]        start [N],
    output logic [PW-1:0]        count [N],
    output logic [2:0]           perm  [N]
);
    import art_pkg::*;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        art_cell_ctl_t ctl;
        logic [PW-1:0] p_start, p_count, n_start, n_count;
        logic [2:0]    p_perm, n_perm;

        assign ctl.load_new  = op.insert && (pos == CNTW'(i));
        assign ctl.take_prev = op.insert && (pos < CNTW'(i));
        assign ctl.take_next = op.remove && (pos <= CNTW'(i));
        assign ctl.set_perm  = op.set_perm && (pos == CNTW'(i));

        if (i == 0)
        begin : g_first
            assign p_start = new_start;
            assign p_count = new_count;
            assign p_perm  = new_perm;
        end
        else
        begin : g_mid
            assign p_start = start[i-1];
            assign p_count = count[i-1];
            assign p_perm  = perm[i-1];
        end

        if (i == N - 1)
        begin : g_last
            assign n_start = start[i];
            assign n_count = count[i];
            assign n_perm  = perm[i];
        end
        else
        begin : g_inner
            assign n_start = start[i+1];
            assign n_count = count[i+1];
            assign n_perm  = perm[i+1];
        end

        art_cell #(.PW(PW)) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .new_start  (new_start),
            .new_count  (new_count),
            .new_perm   (new_perm),
            .prev_start (p_start),
            .prev_count (p_count),
            .prev_perm  (p_perm),
            .next_start (n_start),
            .next_count (n_count),
            .next_perm  (n_perm),
            .start      (start[i]),
            .count      (count[i]),
            .perm       (perm[i])
        );
    end

endmodule

// ===== design/address_region_table.sv =====
// ----------------------------------------------------------------------------
// Address region table
// Sorted table of page-aligned regions with map, unmap, protect, check and search.
// ----------------------------------------------------------------------------
// Commands arrive on in_ch, one result per command leaves on out_ch, both
// valid/ready; a transfer happens when valid and ready are high together.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, as the block itself does not enforce it.
// One command is processed at a time. The sequencer walks the cell row one
// region per cycle in its scan state; find free goes back to its limit check
// and rescans from the first region after every overlap it skips. Commands
// rejected by their bounds checks go from idle straight to the done state.
// The result sits in an output register; the next command is accepted in the
// cycle after a result is loaded, but the next result is held back until
// out_ch takes the previous. Reset empties the table and loads the register
// defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
`include "address_region_table_defines.svh"

module address_region_table #(
    parameter int MAX_REGIONS = 16,
    parameter int PAGE_BYTES  = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    art_in_if.sink      in_ch,
    art_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import art_pkg::*;

    localparam int PB   = $clog2(PAGE_BYTES);
    localparam int PW   = 32 - PB;
    localparam int IDXW = $clog2(MAX_REGIONS);
    localparam int CNTW = $clog2(MAX_REGIONS + 1);
    localparam logic [31:0] OVF_LIMIT = 32'hFFFF_FFFF - 32'(PAGE_BYTES - 1);
    localparam logic [31:0] PAGE_MASK = 32'(PAGE_BYTES - 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LIMIT, S_COMMIT, S_DONE} state_t;

    function automatic logic range_ok(input logic [31:0] s, input logic [31:0] n,
                                      input logic [31:0] lo, input logic [31:0] top);
        range_ok = (n != 32'd0) && (s[PB-1:0] == '0) && (n[PB-1:0] == '0) &&
                   (s >= lo) && (s < top) && (n <= top - s);
    endfunction

    state_t          state_reg, state_next;
    art_cmd_t        cmd_reg, cmd_next;
    logic [31:0]     a_reg, a_next, n_reg, n_next;
    logic [2:0]      p_reg, p_next;
    logic [CNTW-1:0] idx_reg, idx_next, pos_reg, pos_next, count_reg, count_next;
    logic [32:0]     cur_reg, cur_next;
    logic [31:0]     low_reg, top_reg, base_reg, floor_reg;

    art_status_t     res_status_reg, res_status_next;
    logic [31:0]     res_addr_reg, res_addr_next, res_len_reg, res_len_next;
    logic [2:0]      res_perm_reg, res_perm_next;
    logic            res_found_reg, res_found_next;

    logic            outv_reg, outv_next;
    art_status_t     out_status_reg;
    logic [31:0]     out_addr_reg, out_len_reg;
    logic [2:0]      out_perm_reg;
    logic            out_found_reg;
    logic            out_load;

    art_row_op_t     row_op;
    logic [CNTW-1:0] row_pos;
    logic [PW-1:0]   row_new_start;
    logic [PW-1:0]   cell_start [MAX_REGIONS];
    logic [PW-1:0]   cell_count [MAX_REGIONS];
    logic [2:0]      cell_perm  [MAX_REGIONS];

    logic [31:0]     rs, sz;
    logic [32:0]     re, a33, end33, s_end33, limit33;
    logic [2:0]      rp;
    logic            valid_i;
    logic [31:0]     ia, inn, span, nr, s_init;
    art_cmd_t        icmd;

    // current cell
    assign rs      = {cell_start[idx_reg[IDXW-1:0]], PB'(0)};
    assign sz      = {cell_count[idx_reg[IDXW-1:0]], PB'(0)};
    assign rp      = cell_perm[idx_reg[IDXW-1:0]];
    assign re      = {1'b0, rs} + {1'b0, sz};
    assign valid_i = idx_reg < count_reg;
    assign a33     = {1'b0, a_reg};
    assign end33   = a33 + {1'b0, n_reg};
    assign s_end33 = {1'b0, cur_reg[31:0]} + {1'b0, n_reg};
    assign limit33 = (floor_reg > STACK_GUARD) ? {1'b0, floor_reg - STACK_GUARD}
                                               : {1'b0, top_reg};

    assign ia     = in_ch.base_address;
    assign inn    = in_ch.length;
    assign icmd   = art_cmd_t'(in_ch.command);
    assign span   = (top_reg >= base_reg) ? top_reg - base_reg : 32'd0;
    assign nr     = (inn + PAGE_MASK) & ~PAGE_MASK;
    assign s_init = (ia >= base_reg && ia[PB-1:0] == '0) ? ia : base_reg;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_load    = (state_reg == S_DONE) && (!outv_reg || out_ch.ready);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        a_next          = a_reg;
        n_next          = n_reg;
        p_next          = p_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_len_next    = res_len_reg;
        res_perm_next   = res_perm_reg;
        res_found_next  = res_found_reg;
        row_op          = '0;
        row_pos         = idx_reg;
        row_new_start   = (cmd_reg == CMD_FIND_FREE) ? cur_reg[31:PB] : a_reg[31:PB];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    cmd_next        = icmd;
                    a_next          = ia;
                    n_next          = inn;
                    p_next          = in_ch.perms;
                    idx_next        = '0;
                    pos_next        = '0;
                    cur_next        = {1'b0, ia};
                    res_status_next = ST_OK;
                    res_addr_next   = '0;
                    res_len_next    = '0;
                    res_perm_next   = '0;
                    res_found_next  = 1'b0;
                    state_next      = S_SCAN;
                    unique case (icmd)
                        CMD_MAP, CMD_MAP_NOREPLACE:
                        begin
                            if (!range_ok(ia, inn, low_reg, top_reg))
                            begin
                                res_status_next = ST_INVALID;
                                state_next      = S_DONE;
                            end
                        end
                        CMD_UNMAP, CMD_PROTECT:
                        begin
                        end
                        CMD_CHECK:
                        begin
                            if (inn == 32'd0 || ia < low_reg || ia >= top_reg ||
                                inn > top_reg - ia)
                            begin
                                res_status_next = ST_FAULT;
                                state_next      = S_DONE;
                            end
                        end
                        CMD_FIND_FREE:
                        begin
                            n_next     = nr;
                            cur_next   = {1'b0, s_init};
                            state_next = S_LIMIT;
                            if (inn == 32'd0 || inn > span)
                            begin
                                res_status_next = ST_INVALID;
                                state_next      = S_DONE;
                            end
                            else if (inn > OVF_LIMIT)
                            begin
                                res_status_next = ST_OVERFLOW;
                                state_next      = S_DONE;
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            if (inn == 32'd0 || ia > ~inn)
                            begin
                                state_next = S_DONE;
                            end
                        end
                        CMD_RESERVED:
                        begin
                            res_status_next = ST_INVALID;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end

            S_LIMIT:
            begin
                idx_next = '0;
                if (cur_reg >= limit33 || {1'b0, n_reg} > limit33 - cur_reg)
                begin
                    res_status_next = ST_NOMEM;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                unique case (cmd_reg)
                    CMD_MAP, CMD_MAP_NOREPLACE:
                    begin
                        if (!valid_i)
                        begin
                            state_next = S_COMMIT;
                        end
                        else if (a33 < re && {1'b0, rs} < end33)
                        begin
                            res_status_next = (cmd_reg == CMD_MAP) ? ST_INVALID : ST_EXISTS;
                            state_next      = S_DONE;
                        end
                        else if (rs < a_reg)
                        begin
                            pos_next = idx_reg + 1'b1;
                        end
                    end
                    CMD_UNMAP, CMD_PROTECT:
                    begin
                        if (!valid_i)
                        begin
                            res_status_next = ST_INVALID;
                            state_next      = S_DONE;
                        end
                        else if (rs == a_reg && sz == n_reg)
                        begin
                            if (cmd_reg == CMD_UNMAP)
                            begin
                                row_op.remove = 1'b1;
                                count_next    = count_reg - 1'b1;
                            end
                            else
                            begin
                                row_op.set_perm = 1'b1;
                            end
                            state_next = S_DONE;
                        end
                    end
                    CMD_CHECK:
                    begin
                        if (!valid_i || cur_reg >= end33)
                        begin
                            res_status_next = (cur_reg == end33) ? ST_OK : ST_FAULT;
                            state_next      = S_DONE;
                        end
                        else if (cur_reg < {1'b0, rs})
                        begin
                            res_status_next = ST_FAULT;
                            state_next      = S_DONE;
                        end
                        else if (cur_reg < re)
                        begin
                            if ((rp & p_reg) != p_reg)
                            begin
                                res_status_next = ST_FAULT;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                cur_next = (re < end33) ? re : end33;
                            end
                        end
                    end
                    CMD_FIND_FREE:
                    begin
                        if (!valid_i)
                        begin
                            pos_next   = count_reg;
                            state_next = S_COMMIT;
                        end
                        else if (s_end33 <= {1'b0, rs})
                        begin
                            pos_next   = idx_reg;
                            state_next = S_COMMIT;
                        end
                        else if (cur_reg < re)
                        begin
                            cur_next   = re;
                            state_next = S_LIMIT;
                        end
                    end
                    CMD_LOOKUP:
                    begin
                        if (!valid_i)
                        begin
                            state_next = S_DONE;
                        end
                        else if (a33 >= {1'b0, rs} && end33 <= re)
                        begin
                            res_addr_next  = rs;
                            res_len_next   = sz;
                            res_perm_next  = rp;
                            res_found_next = 1'b1;
                            state_next     = S_DONE;
                        end
                    end
                    CMD_RESERVED:
                    begin
                        res_status_next = ST_INVALID;
                        state_next      = S_DONE;
                    end
                endcase
            end

            S_COMMIT:
            begin
                row_pos    = pos_reg;
                state_next = S_DONE;
                if (cmd_reg == CMD_FIND_FREE &&
                    !range_ok(cur_reg[31:0], n_reg, low_reg, top_reg))
                begin
                    res_status_next = ST_INVALID;
                end
                else if (count_reg >= CNTW'(MAX_REGIONS))
                begin
                    res_status_next = ST_NOMEM;
                end
                else
                begin
                    row_op.insert   = 1'b1;
                    count_next      = count_reg + 1'b1;
                    res_status_next = ST_OK;
                    if (cmd_reg == CMD_FIND_FREE)
                    begin
                        res_addr_next = cur_reg[31:0];
                        res_len_next  = n_reg;
                    end
                end
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        outv_next = outv_reg;
        if (out_load)
        begin
            outv_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            outv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            outv_reg  <= 1'b0;
            low_reg   <= RST_USER_LOW;
            top_reg   <= RST_USER_TOP;
            base_reg  <= RST_MMAP_BASE;
            floor_reg <= RST_STACK_FLOOR;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            outv_reg  <= outv_next;
            if (cfg_we)
            begin
                unique case (art_cfg_idx_t'(cfg_index))
                    CFG_USER_LOW:    low_reg   <= cfg_data;
                    CFG_USER_TOP:    top_reg   <= cfg_data;
                    CFG_MMAP_BASE:   base_reg  <= cfg_data;
                    CFG_STACK_FLOOR: floor_reg <= cfg_data;
                    default:         low_reg   <= low_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        a_reg          <= a_next;
        n_reg          <= n_next;
        p_reg          <= p_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        cur_reg        <= cur_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_len_reg    <= res_len_next;
        res_perm_reg   <= res_perm_next;
        res_found_reg  <= res_found_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
            out_len_reg    <= res_len_reg;
            out_perm_reg   <= res_perm_reg;
            out_found_reg  <= res_found_reg;
        end
    end

    art_cell_row #(
        .N    (MAX_REGIONS),
        .PW   (PW),
        .CNTW (CNTW)
    ) u_row (
        .clk       (clk),
        .op        (row_op),
        .pos       (row_pos),
        .new_start (row_new_start),
        .new_count (n_reg[31:PB]),
        .new_perm  (p_reg),
        .start     (cell_start),
        .count     (cell_count),
        .perm      (cell_perm)
    );

    assign out_ch.valid          = outv_reg;
    assign out_ch.status         = out_status_reg;
    assign out_ch.result_address = out_addr_reg;
    assign out_ch.result_length  = out_len_reg;
    assign out_ch.result_perms   = out_perm_reg;
    assign out_ch.found          = out_found_reg;

    `ART_ASSERT(a_count_bound, count_reg <= CNTW'(MAX_REGIONS))
    `ART_ASSERT_IMP(a_count_step, count_reg != $past(count_reg),
        (count_reg == $past(count_reg) + 1'b1) || (count_reg == $past(count_reg) - 1'b1))
    `ART_ASSERT_IMP(a_found_ok, outv_reg && out_found_reg, out_status_reg == ST_OK)
    `ART_ASSERT_IMP(a_busy_after_accept, in_ch.valid && in_ch.ready, ##1 state_reg != S_IDLE)

endmodule

// ===== sim/tb_address_region_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Address region table testbench
// Drives map, unmap, protect, check, find-free and lookup commands through
// the valid/ready channels under several bound settings, with random gaps and
// stalls on both sides. A scoreboard keeps its own copy of the region table,
// predicts the result of every accepted command and compares each result
// transfer field by field, in order.
// ----------------------------------------------------------------------------
module tb_address_region_table;
    import art_pkg::*;

    typedef struct {
        art_status_t status;
        logic [31:0] addr;
        logic [31:0] len;
        logic [2:0]  perms;
        logic        found;
    } region_result_t;

    class region_scoreboard;
        localparam int NREG = 16;
        localparam longint unsigned PG = 4096;

        logic [31:0] low_bound, top_bound, mmap_base, stack_floor;
        longint unsigned start_pg[NREG];
        longint unsigned npages[NREG];
        logic [2:0] perm[NREG];
        int count;
        region_result_t expected_q[$];
        int errors, n_cmds, n_results;

        function new();
            low_bound = RST_USER_LOW;
            top_bound = RST_USER_TOP;
            mmap_base = RST_MMAP_BASE;
            stack_floor = RST_STACK_FLOOR;
            count = 0;
            errors = 0;
            n_cmds = 0;
            n_results = 0;
        endfunction

        function void set_reg(art_cfg_idx_t idx, logic [31:0] v);
            case (idx)
                CFG_USER_LOW:    low_bound = v;
                CFG_USER_TOP:    top_bound = v;
                CFG_MMAP_BASE:   mmap_base = v;
                CFG_STACK_FLOOR: stack_floor = v;
            endcase
        endfunction

        function longint unsigned rstart(int i);
            return start_pg[i] * PG;
        endfunction

        function longint unsigned rend(int i);
            return (start_pg[i] + npages[i]) * PG;
        endfunction

        function bit range_fits(longint unsigned s, longint unsigned n);
            return n != 0 && s % PG == 0 && n % PG == 0 && s >= low_bound && s < top_bound
                   && n <= top_bound - s;
        endfunction

        function bit overlaps(longint unsigned s, longint unsigned n);
            for (int i = 0; i < count; i++)
                if (s < rend(i) && rstart(i) < s + n)
                    return 1;
            return 0;
        endfunction

        function art_status_t insert(longint unsigned s, longint unsigned n, logic [2:0] p);
            int pos;
            pos = 0;
            if (count >= NREG)
                return ST_NOMEM;
            while (pos < count && rstart(pos) < s)
                pos++;
            for (int i = count; i > pos; i--)
            begin
                start_pg[i] = start_pg[i-1];
                npages[i] = npages[i-1];
                perm[i] = perm[i-1];
            end
            start_pg[pos] = s / PG;
            npages[pos] = n / PG;
            perm[pos] = p;
            count++;
            return ST_OK;
        endfunction

        function int exact_index(longint unsigned s, longint unsigned n);
            for (int i = 0; i < count; i++)
                if (rstart(i) == s && rend(i) - rstart(i) == n)
                    return i;
            return -1;
        endfunction

        function art_status_t covered(longint unsigned a, longint unsigned n, logic [2:0] req);
            longint unsigned cur, stop;
            if (n == 0 || a < low_bound || a >= top_bound || n > top_bound - a)
                return ST_FAULT;
            cur = a;
            stop = a + n;
            for (int i = 0; i < count && cur < stop; i++)
            begin
                if (cur < rstart(i))
                    return ST_FAULT;
                if (cur >= rend(i))
                    continue;
                if ((perm[i] & req) != req)
                    return ST_FAULT;
                cur = rend(i) < stop ? rend(i) : stop;
            end
            return cur == stop ? ST_OK : ST_FAULT;
        endfunction

        function art_status_t place_first_fit(longint unsigned hint, longint unsigned n,
                                              logic [2:0] p, ref region_result_t r);
            longint unsigned span, lim, s;
            bit moved;
            art_status_t st;
            span = top_bound >= mmap_base ? top_bound - mmap_base : 0;
            if (n == 0 || n > span)
                return ST_INVALID;
            if (n > 64'hFFFF_FFFF - (PG - 1))
                return ST_OVERFLOW;
            n = ((n + PG - 1) / PG) * PG;
            lim = stack_floor > STACK_GUARD ? stack_floor - STACK_GUARD : top_bound;
            s = (hint >= mmap_base && hint % PG == 0) ? hint : mmap_base;
            do
            begin
                moved = 0;
                if (s >= lim || n > lim - s)
                    return ST_NOMEM;
                for (int i = 0; i < count; i++)
                begin
                    if (s + n <= rstart(i))
                        break;
                    if (s < rend(i))
                    begin
                        s = rend(i);
                        moved = 1;
                        break;
                    end
                end
            end
            while (moved);
            if (!range_fits(s, n) || overlaps(s, n))
                return ST_INVALID;
            st = insert(s, n, p);
            if (st == ST_OK)
            begin
                r.addr = s;
                r.len = n;
            end
            return st;
        endfunction

        function void note_command(art_cmd_t cmd, logic [31:0] a32, logic [31:0] n32,
                                   logic [2:0] p);
            region_result_t r;
            longint unsigned a, n;
            int k;
            a = a32;
            n = n32;
            r.status = ST_INVALID;
            r.addr = 0;
            r.len = 0;
            r.perms = 0;
            r.found = 0;
            case (cmd)
                CMD_MAP:
                    if (!range_fits(a, n) || overlaps(a, n))
                        r.status = ST_INVALID;
                    else
                        r.status = insert(a, n, p);
                CMD_MAP_NOREPLACE:
                    if (!range_fits(a, n))
                        r.status = ST_INVALID;
                    else if (overlaps(a, n))
                        r.status = ST_EXISTS;
                    else
                        r.status = insert(a, n, p);
                CMD_UNMAP:
                begin
                    k = exact_index(a, n);
                    if (k >= 0)
                    begin
                        for (int i = k; i < count - 1; i++)
                        begin
                            start_pg[i] = start_pg[i+1];
                            npages[i] = npages[i+1];
                            perm[i] = perm[i+1];
                        end
                        count--;
                        r.status = ST_OK;
                    end
                end
                CMD_PROTECT:
                begin
                    k = exact_index(a, n);
                    if (k >= 0)
                    begin
                        perm[k] = p;
                        r.status = ST_OK;
                    end
                end
                CMD_CHECK:
                    r.status = covered(a, n, p);
                CMD_FIND_FREE:
                    r.status = place_first_fit(a, n, p, r);
                CMD_LOOKUP:
                begin
                    r.status = ST_OK;
                    if (n != 0 && a <= 64'hFFFF_FFFF - n)
                        for (int i = 0; i < count; i++)
                            if (a >= rstart(i) && a + n <= rend(i))
                            begin
                                r.addr = rstart(i);
                                r.len = rend(i) - rstart(i);
                                r.perms = perm[i];
                                r.found = 1;
                                break;
                            end
                end
                default:
                    r.status = ST_INVALID;
            endcase
            expected_q.push_back(r);
            n_cmds++;
        endfunction

        function void check_result(logic [2:0] st, logic [31:0] addr, logic [31:0] len,
                                   logic [2:0] p, logic fnd);
            region_result_t e;
            n_results++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result transfer status=%0d addr=%h", $time, st,
                         addr);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (st !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (addr !== e.addr)
            begin
                $display("%0t: result_address expected %h actual %h", $time, e.addr, addr);
                errors++;
            end
            if (len !== e.len)
            begin
                $display("%0t: result_length expected %h actual %h", $time, e.len, len);
                errors++;
            end
            if (p !== e.perms)
            begin
                $display("%0t: result_perms expected %0d actual %0d", $time, e.perms, p);
                errors++;
            end
            if (fnd !== e.found)
            begin
                $display("%0t: found expected %0d actual %0d", $time, e.found, fnd);
                errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 3000000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;
    int cycles;
    bit no_idle;
    bit long_hold_req;
    bit long_hold_done;
    int hold_left;
    int stall_left;

    art_in_if in_ch();
    art_out_if out_ch();
    region_scoreboard sb = new();

    address_region_table dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     sb.expected_q.size());
            $display("tb_address_region_table failed");
            $finish;
        end
    end

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random stalls plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 0;
            hold_left = 0;
            stall_left = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.status, out_ch.result_address, out_ch.result_length,
                                out_ch.result_perms, out_ch.found);
            if (long_hold_req && !long_hold_done)
            begin
                hold_left = 400;
                long_hold_done = 1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 0;
            end
            else
            begin
                stall_left = gap_len();
                out_ch.ready <= (stall_left == 0);
            end
        end
    end

    task automatic send(art_cmd_t cmd, logic [31:0] a, logic [31:0] n, logic [2:0] p);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_ch.valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.command <= cmd;
        in_ch.base_address <= a;
        in_ch.length <= n;
        in_ch.perms <= p;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_command(cmd, a, n, p);
    endtask

    task automatic drain();
        @(posedge clk);
        in_ch.valid <= 0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_reg(art_cfg_idx_t idx, logic [31:0] v);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
        sb.set_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic random_command();
        art_cmd_t cmd;
        logic [31:0] a, n, w;
        logic [2:0] p;
        int r, i;
        r = $urandom_range(0, 99);
        p = $urandom_range(0, 7);
        if (r < 12)
        begin
            cmd = art_cmd_t'($urandom_range(0, 7));
            a = $urandom;
            n = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 20000);
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 20)
                cmd = CMD_MAP;
            else if (r < 28)
                cmd = CMD_MAP_NOREPLACE;
            else if (r < 28 + (sb.count > 10 ? 25 : 12))
                cmd = CMD_UNMAP;
            else if (r < 48)
                cmd = CMD_PROTECT;
            else if (r < 63)
                cmd = CMD_CHECK;
            else if (r < 83)
                cmd = CMD_FIND_FREE;
            else
                cmd = CMD_LOOKUP;
            w = ($urandom_range(0, 1) ? sb.mmap_base : sb.low_bound) & 32'hFFFF_F000;
            a = w + 32'h1000 * $urandom_range(0, 48);
            n = 32'h1000 * $urandom_range(1, 6);
            if (cmd == CMD_FIND_FREE && $urandom_range(0, 1))
                n = $urandom_range(1, 24000);
            if (sb.count > 0 && cmd != CMD_FIND_FREE && $urandom_range(0, 99) < 60)
            begin
                i = $urandom_range(0, sb.count - 1);
                a = sb.rstart(i);
                n = sb.rend(i) - sb.rstart(i);
                if ((cmd == CMD_CHECK || cmd == CMD_LOOKUP) && $urandom_range(0, 1))
                begin
                    a = a + $urandom_range(0, 1) * 32'h1000 + $urandom_range(0, 15);
                    n = $urandom_range(1, 3) * 32'h1000;
                end
            end
        end
        send(cmd, a, n, p);
    endtask

    task automatic random_phase(int items);
        for (int k = 0; k < items; k++)
        begin
            if (k == items / 2)
                no_idle = 1;
            if (k == items / 2 + 40)
                no_idle = 0;
            random_command();
        end
        drain();
    endtask

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = CFG_USER_LOW;
        cfg_data = 0;
        in_ch.valid = 0;
        in_ch.command = CMD_MAP;
        in_ch.base_address = 0;
        in_ch.length = 0;
        in_ch.perms = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send(CMD_MAP, 32'h0000_1000, 32'h1000, 3'd7);
        send(CMD_MAP, 32'h0000_1000, 32'h2000, 3'd1);
        send(CMD_MAP_NOREPLACE, 32'h0000_1000, 32'h1000, 3'd1);
        send(CMD_MAP_NOREPLACE, 32'h0000_3000, 32'h1000, 3'd0);
        send(CMD_MAP, 32'h0000_5001, 32'h1000, 3'd1);
        send(CMD_MAP, 32'h0000_6000, 32'h0, 3'd1);
        send(CMD_MAP, 32'h0000_0000, 32'h1000, 3'd1);
        send(CMD_MAP, 32'hBFFF_F000, 32'h1000, 3'd1);
        send(CMD_MAP, 32'hBFFF_E000, 32'h2000, 3'd1);
        send(CMD_CHECK, 32'h0000_1000, 32'h1000, 3'd5);
        send(CMD_CHECK, 32'h0000_1000, 32'h3000, 3'd0);
        send(CMD_PROTECT, 32'h0000_1000, 32'h1000, 3'd2);
        send(CMD_CHECK, 32'h0000_1000, 32'h1000, 3'd1);
        send(CMD_PROTECT, 32'h0000_1000, 32'h2000, 3'd4);
        send(CMD_LOOKUP, 32'h0000_1800, 32'h10, 3'd0);
        send(CMD_LOOKUP, 32'hFFFF_FFF0, 32'h20, 3'd0);
        send(CMD_LOOKUP, 32'h0000_1000, 32'h0, 3'd0);
        send(CMD_FIND_FREE, 32'h0, 32'h1, 3'd3);
        send(CMD_FIND_FREE, 32'h2000_0000, 32'h1000, 3'd6);
        send(CMD_FIND_FREE, 32'h0, 32'h0, 3'd1);
        send(CMD_FIND_FREE, 32'h0, 32'hFFFF_FFFF, 3'd1);
        send(CMD_UNMAP, 32'h0000_1000, 32'h1000, 3'd0);
        send(CMD_UNMAP, 32'h0000_1000, 32'h1000, 3'd0);
        send(CMD_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
        drain();

        // fill the table, then overflow it; the receiver holds off meanwhile
        long_hold_req = 1;
        for (int k = 0; k < 20; k++)
            send(CMD_FIND_FREE, 32'h0, 32'h1000 * (k % 3 + 1), 3'(k));
        random_phase(300);

        write_reg(CFG_USER_LOW, 32'h0);
        write_reg(CFG_USER_TOP, 32'hFFFF_FFFF);
        write_reg(CFG_MMAP_BASE, 32'h0);
        write_reg(CFG_STACK_FLOOR, 32'h0001_0000);
        send(CMD_FIND_FREE, 32'h0, 32'hFFFF_FFFF, 3'd7);
        send(CMD_FIND_FREE, 32'h0, 32'hFFFF_F001, 3'd7);
        send(CMD_MAP, 32'h0, 32'h1000, 3'd7);
        random_phase(300);

        write_reg(CFG_USER_LOW, 32'h1000_0000);
        write_reg(CFG_MMAP_BASE, 32'h1000_8000);
        write_reg(CFG_STACK_FLOOR, 32'h1002_0000);
        random_phase(300);

        write_reg(CFG_USER_LOW, 32'hFFFF_FFFF);
        write_reg(CFG_USER_TOP, 32'h0);
        write_reg(CFG_MMAP_BASE, 32'hFFFF_FFFF);
        write_reg(CFG_STACK_FLOOR, 32'hFFFF_FFFF);
        random_phase(100);

        write_reg(CFG_USER_LOW, RST_USER_LOW);
        write_reg(CFG_USER_TOP, RST_USER_TOP);
        write_reg(CFG_MMAP_BASE, RST_MMAP_BASE);
        write_reg(CFG_STACK_FLOOR, 32'h1001_0001);
        random_phase(500);

        repeat (300) @(posedge clk);
        $display("%0d commands sent, %0d results checked over five bound settings",
                 sb.n_cmds, sb.n_results);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("tb_address_region_table passed");
        else
            $display("tb_address_region_table failed");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+design
design/art_pkg.sv
design/art_if.sv
design/art_cell.sv
design/art_cell_row.sv
design/address_region_table.sv
sim/tb_address_region_table.sv
